// File: rtl/pctl_pkg.sv
// Package for the PID controller step: widths, codes, configuration and
// multiplier request types. No dependencies.
package pctl_pkg;

  localparam int unsigned ErrW    = 32;            // error sample, Q16.16
  localparam int unsigned MulAW   = 33;            // signed multiplicand
  localparam int unsigned MulBW   = 24;            // unsigned multiplier
  localparam int unsigned ProdW   = MulAW + MulBW; // signed product
  localparam int unsigned MulCntW = $clog2(MulBW + 1);
  localparam int unsigned SumW    = 43;            // p + i + d, exact
  localparam int unsigned TmpW    = 49;            // widest intermediate
  localparam int unsigned LimW    = 31;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 31;

  typedef enum logic {
    CMD_STEP  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_STEP_TIME   = 3'd3,
    CFG_STEP_RATE   = 3'd4,
    CFG_INTEG_LIMIT = 3'd5,
    CFG_OUT_LIMIT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0]     prop_gain;
    logic [23:0]     integ_gain;
    logic [23:0]     deriv_gain;
    logic [15:0]     step_time;
    logic [23:0]     step_rate;
    logic [LimW-1:0] integ_limit;
    logic [LimW-1:0] out_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prop_gain:   24'd65536,
    integ_gain:  24'd6554,
    deriv_gain:  24'd3277,
    step_time:   16'd2185,
    step_rate:   24'd7680,
    integ_limit: 31'd65536,
    out_limit:   31'd131072
  };

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_R,
    ST_DERIV,
    ST_MUL_D,
    ST_SUM,
    ST_PUSH
  } state_e;

endpackage

// File: rtl/pctl_cfg_regs.sv
// Configuration register file for the PID controller step.
// Depends on pctl_pkg.
module pctl_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pctl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pctl_pkg::CfgDatW-1:0]    cfg_wdata_i,
  output pctl_pkg::cfg_t                  cfg_o
);
  import pctl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:   cfg_d.prop_gain   = cfg_wdata_i[23:0];
        CFG_INTEG_GAIN:  cfg_d.integ_gain  = cfg_wdata_i[23:0];
        CFG_DERIV_GAIN:  cfg_d.deriv_gain  = cfg_wdata_i[23:0];
        CFG_STEP_TIME:   cfg_d.step_time   = cfg_wdata_i[15:0];
        CFG_STEP_RATE:   cfg_d.step_rate   = cfg_wdata_i[23:0];
        CFG_INTEG_LIMIT: cfg_d.integ_limit = cfg_wdata_i[LimW-1:0];
        CFG_OUT_LIMIT:   cfg_d.out_limit   = cfg_wdata_i[LimW-1:0];
        default:         cfg_d = cfg_q; // unused index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/pctl_serial_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand by unsigned multiplier,
// one multiplier bit per cycle. Depends on pctl_pkg.
module pctl_serial_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pctl_pkg::mul_req_t            req_i,
  output logic                          done_o,
  output logic [pctl_pkg::ProdW-1:0]    prod_o
);
  import pctl_pkg::*;

  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [MulAW-1:0]   a_q, a_d;
  logic [MulAW:0]     h_q, h_d;   // upper partial product, one guard bit
  logic [MulBW-1:0]   l_q, l_d;   // multiplier bits out, product bits in
  logic [MulAW:0]     add_sum;

  // add the multiplicand when the current multiplier bit is set
  assign add_sum = h_q + (l_q[0] ? {a_q[MulAW-1], a_q} : '0);

  always_comb begin
    cnt_d  = cnt_q;
    a_d    = a_q;
    h_d    = h_q;
    l_d    = l_q;
    done_d = (cnt_q == MulCntW'(1));
    if (req_i.start) begin
      cnt_d = MulCntW'(MulBW);
      a_d   = req_i.a;
      h_d   = '0;
      l_d   = req_i.b;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - MulCntW'(1);
      h_d   = {add_sum[MulAW], add_sum[MulAW:1]};
      l_d   = {add_sum[0], l_q[MulBW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    h_q <= h_d;
    l_q <= l_d;
  end

  assign done_o = done_q;
  assign prod_o = {h_q[MulAW-1:0], l_q};

endmodule

// File: rtl/pctl_core.sv
// Step sequencer and datapath: controller state, clamps and the running sum,
// driving the shared serial multiplier. Depends on pctl_pkg.
module pctl_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pctl_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  input  logic                          cmd_i,
  input  logic [pctl_pkg::ErrW-1:0]     error_in_i,
  output logic                          in_stall_o,
  output logic                          push_o,
  input  logic                          push_ok_i,
  output logic [pctl_pkg::ErrW-1:0]     result_o,
  output pctl_pkg::mul_req_t            mul_req_o,
  input  logic                          mul_done_i,
  input  logic [pctl_pkg::ProdW-1:0]    mul_prod_i
);
  import pctl_pkg::*;

  state_e state_q, state_d;
  logic   entry_q, entry_d;
  logic   first_q, first_d;
  logic [ErrW-1:0]  integ_q, integ_d;
  logic [ErrW-1:0]  prev_q, prev_d;
  logic [ErrW-1:0]  e_q, e_d;
  logic [MulAW-1:0] diff_q, diff_d;
  logic [TmpW-1:0]  tmp_q, tmp_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [ErrW-1:0]  res_q, res_d;
  logic             accept;
  logic             is_mul;
  logic [ErrW-1:0]  deriv_sat;

  // symmetric clamp to +/-lim, result fits 32 bits signed
  function automatic logic [ErrW-1:0] clamp_sym(input logic [TmpW-1:0] x,
                                                input logic [LimW-1:0] lim);
    logic signed [TmpW-1:0] xs;
    logic signed [TmpW-1:0] lp;
    logic signed [TmpW-1:0] ln;
    logic [ErrW-1:0]        lim32;
    xs    = signed'(x);
    lp    = signed'({{(TmpW-LimW){1'b0}}, lim});
    ln    = -lp;
    lim32 = {1'b0, lim};
    if (xs > lp) begin
      clamp_sym = lim32;
    end else if (xs < ln) begin
      clamp_sym = -lim32;
    end else begin
      clamp_sym = x[ErrW-1:0];
    end
  endfunction

  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign is_mul = (state_q == ST_MUL_T) || (state_q == ST_MUL_P) || (state_q == ST_MUL_I)
               || (state_q == ST_MUL_R) || (state_q == ST_MUL_D);

  // derivative saturated to the signed 32-bit range
  always_comb begin
    if ((&tmp_q[TmpW-1:ErrW-1]) || !(|tmp_q[TmpW-1:ErrW-1])) begin
      deriv_sat = tmp_q[ErrW-1:0];
    end else if (tmp_q[TmpW-1]) begin
      deriv_sat = {1'b1, {(ErrW-1){1'b0}}};
    end else begin
      deriv_sat = {1'b0, {(ErrW-1){1'b1}}};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i && (cmd_e'(cmd_i) == CMD_STEP)) state_d = ST_MUL_T;
      ST_MUL_T: if (mul_done_i) state_d = ST_INTEG;
      ST_INTEG: state_d = ST_MUL_P;
      ST_MUL_P: if (mul_done_i) state_d = ST_MUL_I;
      ST_MUL_I: if (mul_done_i) state_d = ST_MUL_R;
      ST_MUL_R: if (mul_done_i) state_d = ST_DERIV;
      ST_DERIV: state_d = ST_MUL_D;
      ST_MUL_D: if (mul_done_i) state_d = ST_SUM;
      ST_SUM:   state_d = ST_PUSH;
      ST_PUSH:  if (push_ok_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign entry_d = (state_d != state_q);

  // outputs: handshake and multiplier request
  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    push_o          = (state_q == ST_PUSH);
    mul_req_o.start = entry_q && is_mul;
    mul_req_o.a     = {e_q[ErrW-1], e_q};
    mul_req_o.b     = '0;
    unique case (state_q)
      ST_MUL_T: mul_req_o.b = {8'd0, cfg_i.step_time};
      ST_MUL_P: mul_req_o.b = cfg_i.prop_gain;
      ST_MUL_I: begin
        mul_req_o.a = {integ_q[ErrW-1], integ_q};
        mul_req_o.b = cfg_i.integ_gain;
      end
      ST_MUL_R: begin
        mul_req_o.a = diff_q;
        mul_req_o.b = cfg_i.step_rate;
      end
      ST_MUL_D: begin
        mul_req_o.a = diff_q;
        mul_req_o.b = cfg_i.deriv_gain;
      end
      default: mul_req_o.b = '0;
    endcase
  end

  // datapath
  always_comb begin
    first_d = first_q;
    integ_d = integ_q;
    prev_d  = prev_q;
    e_d     = e_q;
    diff_d  = diff_q;
    tmp_d   = tmp_q;
    sum_d   = sum_q;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_e'(cmd_i) == CMD_CLEAR) begin
            integ_d = '0;
            prev_d  = '0;
            first_d = 1'b1;
          end else begin
            e_d     = error_in_i;
            diff_d  = first_q ? '0
                              : ({error_in_i[ErrW-1], error_in_i} - {prev_q[ErrW-1], prev_q});
            prev_d  = error_in_i;
            first_d = 1'b0;
            sum_d   = '0;
          end
        end
      end
      ST_MUL_T: begin
        if (mul_done_i) begin
          // integral + (e*dt >> 16)
          tmp_d = {{(TmpW-ErrW){integ_q[ErrW-1]}}, integ_q}
                + {{(TmpW-ErrW){mul_prod_i[47]}}, mul_prod_i[47:16]};
        end
      end
      ST_INTEG: integ_d = clamp_sym(tmp_q, cfg_i.integ_limit);
      ST_MUL_P, ST_MUL_I, ST_MUL_D: begin
        if (mul_done_i) begin
          sum_d = sum_q + {{(SumW-(ProdW-16)){mul_prod_i[ProdW-1]}},
                           mul_prod_i[ProdW-1:16]};
        end
      end
      ST_MUL_R: if (mul_done_i) tmp_d = mul_prod_i[ProdW-1:8];
      ST_DERIV: diff_d = {deriv_sat[ErrW-1], deriv_sat};
      ST_SUM:   res_d  = clamp_sym({{(TmpW-SumW){sum_q[SumW-1]}}, sum_q}, cfg_i.out_limit);
      ST_PUSH:  res_d  = res_q;
      default:  res_d  = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      entry_q <= 1'b0;
      first_q <= 1'b1;
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      entry_q <= entry_d;
      first_q <= first_d;
      integ_q <= integ_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    diff_q <= diff_d;
    tmp_q  <= tmp_d;
    sum_q  <= sum_d;
    res_q  <= res_d;
  end

  assign result_o = res_q;

endmodule

// File: rtl/pid_controller_step.sv
// Top level of the PID controller step: configuration registers, sequencer,
// serial multiplier and the output register. Depends on pctl_pkg and submodules.
//
//  channel   direction  handshake                   payload
//  -------   ---------  --------------------------  --------------------------
//  input     in         in_valid_i / in_stall_o     cmd_i, error_in_i
//  output    out        out_valid_o / out_stall_i   drive_out_o
//  config    in         cfg_we_i (no wait)          cfg_idx_i, cfg_wdata_i
//
// A compute request runs five products in turn on the single bit-serial multiplier,
// with the integral clamp, derivative saturation, sum and push states among and
// after them; the next request is taken only once the block is back in idle.
// A clear request gives no result and leaves the block idle.
// Reset (rst_ni, asynchronous, active low) restores the register defaults,
// zeroes integral and previous error and arms the first-sample flag.
// The output register decouples the sides: a finished result waits there
// under out_stall_i while the next request is already being worked on.
module pid_controller_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [pctl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pctl_pkg::CfgDatW-1:0]  cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic signed [31:0]            error_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            drive_out_o
);
  import pctl_pkg::*;

  cfg_t            cfg;
  mul_req_t        mul_req;
  logic            mul_done;
  logic [ProdW-1:0] mul_prod;
  logic            push;
  logic            push_ok;
  logic [ErrW-1:0] result;

  logic            out_valid_q, out_valid_d;
  logic [ErrW-1:0] drive_q, drive_d;

  pctl_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pctl_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  pctl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .error_in_i (error_in_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .push_ok_i  (push_ok),
    .result_o   (result),
    .mul_req_o  (mul_req),
    .mul_done_i (mul_done),
    .mul_prod_i (mul_prod)
  );

  // output register: free when empty or being taken this cycle
  assign push_ok = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    drive_d     = drive_q;
    if (push && push_ok) begin
      out_valid_d = 1'b1;
      drive_d     = result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk_i) begin
    drive_q <= drive_d;
  end

  assign out_valid_o = out_valid_q;
  assign drive_out_o = drive_q;

endmodule

// File: dv/pid_drive_check.sv
`timescale 1ns / 1ps
// Checker for the PID controller step: watches the register port and both
// channels, predicts drive_out and compares. Depends on pctl_pkg.
module pid_drive_check
  import pctl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDatW-1:0]       cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     cmd_i,
  input  logic signed [31:0]       error_in_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [31:0]       drive_out_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              steps_o,
  output int unsigned              clears_o,
  output int unsigned              checked_o
);

  localparam longint DerivMax = 64'sd2147483647;
  localparam longint DerivMin = -64'sd2147483648;
  localparam int unsigned PrintCap = 20;

  cfg_t               regs;
  logic signed [31:0] integ_acc;
  logic signed [31:0] last_error;
  logic               fresh;
  logic signed [31:0] drive_q [$];
  logic signed [31:0] want;
  logic signed [31:0] next_drive;
  int unsigned        fails, steps, clears, checked;

  function automatic longint clamp_sym(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // One compute step; updates the integral and the previous error.
  function automatic logic signed [31:0] predict_drive(logic signed [31:0] e);
    longint ev, prev, acc, p, i_term, deriv, d, sum;
    ev    = e;
    prev  = fresh ? ev : longint'(last_error);
    fresh = 1'b0;
    p     = (longint'(regs.prop_gain) * ev) >>> 16;
    acc   = longint'(integ_acc) + ((ev * longint'(regs.step_time)) >>> 16);
    acc   = clamp_sym(acc, longint'(regs.integ_limit));
    integ_acc = acc[31:0];
    i_term = (longint'(regs.integ_gain) * acc) >>> 16;
    deriv = ((ev - prev) * longint'(regs.step_rate)) >>> 8;
    if (deriv > DerivMax) deriv = DerivMax;
    if (deriv < DerivMin) deriv = DerivMin;
    d     = (longint'(regs.deriv_gain) * deriv) >>> 16;
    sum   = clamp_sym(p + i_term + d, longint'(regs.out_limit));
    last_error = e;
    return sum[31:0];
  endfunction

  task automatic clear_state();
    integ_acc  = '0;
    last_error = '0;
    fresh      = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    fails++;
    if (fails <= PrintCap)
      $display("[%0t] drive_out: %s, got %h expected %h", $realtime, what, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = CfgReset;
      clear_state();
      drive_q.delete();
      fails   = 0;
      steps   = 0;
      clears  = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      steps_o      <= 0;
      clears_o     <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PROP_GAIN:   regs.prop_gain   = cfg_wdata_i[23:0];
          CFG_INTEG_GAIN:  regs.integ_gain  = cfg_wdata_i[23:0];
          CFG_DERIV_GAIN:  regs.deriv_gain  = cfg_wdata_i[23:0];
          CFG_STEP_TIME:   regs.step_time   = cfg_wdata_i[15:0];
          CFG_STEP_RATE:   regs.step_rate   = cfg_wdata_i[23:0];
          CFG_INTEG_LIMIT: regs.integ_limit = cfg_wdata_i[LimW-1:0];
          CFG_OUT_LIMIT:   regs.out_limit   = cfg_wdata_i[LimW-1:0];
          default: ;
        endcase
      end
      // result first: it can never belong to a request taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          report_mismatch("result with no request outstanding", drive_out_i, 'x);
        end else begin
          want = drive_q.pop_front();
          checked++;
          if (drive_out_i !== want) report_mismatch("value", drive_out_i, want);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_CLEAR) begin
          clear_state();
          clears++;
        end else begin
          next_drive = predict_drive(error_in_i);
          drive_q    = {drive_q, next_drive};
          steps++;
        end
      end
      fail_count_o <= fails;
      pending_o    <= drive_q.size();
      steps_o      <= steps;
      clears_o     <= clears;
      checked_o    <= checked;
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the PID controller step bench: clock, reset, request stimulus,
// result back-pressure and verdict. Depends on pctl_pkg and pid_drive_check.
module testbench;
  import pctl_pkg::*;

  localparam int unsigned IdleLimit   = 3000; // cycles with no handshake and no register write
  localparam int unsigned Phases      = 10;
  localparam int unsigned PhaseItems  = 150;  // random requests per setting
  localparam int unsigned DrainEvery  = 100;
  localparam int unsigned TailCycles  = 150;  // pad after the last result is back

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDatW-1:0]  cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                cmd_i       = CMD_STEP;
  logic signed [31:0]  error_in_i  = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic signed [31:0]  drive_out_o;

  int unsigned fail_count, pending, steps, clears, checked;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  int unsigned settings_run = 0;
  bit          send_gaps    = 1'b1;
  bit          recv_stalls  = 1'b1;
  logic signed [31:0] last_err = '0;

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pid_controller_step dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .error_in_i  (error_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_out_o (drive_out_o)
  );

  pid_drive_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cmd_i        (cmd_i),
    .error_in_i   (error_in_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_out_i  (drive_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .steps_o      (steps),
    .clears_o     (clears),
    .checked_o    (checked)
  );

  // Gap length: mostly none or short, now and then long. The longest ones
  // outlast a whole compute so they also land while the block sits idle.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    if (r < 99) return $urandom_range(80, 20);
    return $urandom_range(200, 140);
  endfunction

  // Error mix: holding the last value winds the integral into its clamp,
  // extremes push the derivative into saturation, full random hits every bit.
  function automatic logic signed [31:0] pick_error();
    logic signed [31:0] v;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return last_err;
    if (r < 35) begin
      case ($urandom_range(4))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r < 50) return $urandom;
    if (r < 80) v = $urandom_range(32'h3_FFFF);   // a few units either way
    else        v = $urandom_range(32'h3FF_FFFF);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.prop_gain   = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(32'h3_FFFF));
    c.integ_gain  = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(32'h3_FFFF));
    c.deriv_gain  = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(32'h3_FFFF));
    c.step_time   = 16'($urandom);
    c.step_rate   = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(32'h8000));
    c.integ_limit = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h7_FFFF));
    c.out_limit   = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h7_FFFF));
    return c;
  endfunction

  // One request: optional gap, then hold valid and payload until taken.
  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_request(input cmd_e op, input logic signed [31:0] err);
    int unsigned gap;
    gap = send_gaps ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    error_in_i <= err;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Wait until every expected result is back; a trailing clear may still be
  // settling, so pad before the registers are touched.
  task automatic drain(input int unsigned pad);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDatW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t c);
    drain(8);
    write_reg(CFG_PROP_GAIN,   CfgDatW'(c.prop_gain));
    write_reg(CFG_INTEG_GAIN,  CfgDatW'(c.integ_gain));
    write_reg(CFG_DERIV_GAIN,  CfgDatW'(c.deriv_gain));
    write_reg(CFG_STEP_TIME,   CfgDatW'(c.step_time));
    write_reg(CFG_STEP_RATE,   CfgDatW'(c.step_rate));
    write_reg(CFG_INTEG_LIMIT, CfgDatW'(c.integ_limit));
    write_reg(CFG_OUT_LIMIT,   CfgDatW'(c.out_limit));
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Result side: stalls start at random while free, with lengths drawn from idle_len.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (recv_stalls && $urandom_range(7) == 0) stall_left <= idle_len() + 1;
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= IdleLimit);
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             IdleLimit, pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    cfg_t c;
    logic signed [31:0] err;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset defaults.
    send_request(CMD_STEP,  32'sh0000_0000);   // first sample: no derivative
    send_request(CMD_STEP,  32'sh7FFF_FFFF);   // largest error, output clamps
    send_request(CMD_STEP,  32'sh8000_0000);   // full swing: derivative saturates low
    send_request(CMD_STEP,  -32'sd1);          // floor of tiny negative products
    send_request(CMD_STEP,  32'sd1);
    send_request(CMD_STEP,  32'sh0001_0000);   // steady error winds the integral
    send_request(CMD_STEP,  32'sh0001_0000);
    send_request(CMD_STEP,  32'sh0001_0000);
    send_request(CMD_CLEAR, 32'sh1234_5678);   // error ignored on a clear
    send_request(CMD_STEP,  32'sh8000_0000);   // first sample again after a clear
    send_request(CMD_STEP,  32'sh7FFF_FFFF);   // derivative saturates high
    send_request(CMD_STEP,  32'sh7FFF_FFFF);   // integral sits on its clamp
    send_request(CMD_CLEAR, 32'sh0000_0000);
    send_request(CMD_CLEAR, -32'sd1);          // back-to-back clears
    send_request(CMD_STEP,  -32'sh0001_0000);
    send_request(CMD_STEP,  -32'sh0040_0000);  // negative integral clamp
    send_request(CMD_STEP,  -32'sh0040_0000);

    for (int unsigned ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: c = CfgReset;                       // written back explicitly
        1: c = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1, step_time: '1,
                 step_rate: '1, integ_limit: '1, out_limit: '1};
        2: c = '0;                             // zero gains, periods and clamps
        3: begin                               // zero period and rate, output clamp wide open
          c = random_cfg();
          c.step_time = '0;
          c.step_rate = '0;
          c.out_limit = '1;
        end
        4: begin                               // integral clamp closed, minimal dt
          c = random_cfg();
          c.integ_limit = '0;
          c.step_time   = 16'd1;
          c.step_rate   = 24'd1;
        end
        default: c = random_cfg();
      endcase
      load_settings(c);
      // every third setting runs both sides flat out
      send_gaps   = (ph % 3 != 2);
      recv_stalls = (ph % 3 != 2);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (n != 0 && n % DrainEvery == 0) drain(0);   // sender holds off until empty
        if ($urandom_range(24) == 0) begin
          send_request(CMD_CLEAR, $urandom);
        end else begin
          err = pick_error();
          last_err = err;
          send_request(CMD_STEP, err);
        end
      end
    end

    send_gaps = 1'b1;
    drain(TailCycles);
    $display("Covered %0d step and %0d clear requests over %0d register settings;",
             steps, clears, settings_run + 1);
    $display("%0d drive results compared, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
